@@ hw/rtl/srat_pkg.sv @@
// Shared constants, codes and types for the severity ranked alert table.
package srat_pkg;

  localparam int ENTRIES   = 16;
  localparam int KEY_BITS  = 32;
  localparam int TIME_BITS = 40;
  localparam int SEV_BITS  = 3;
  localparam int FUNC_W    = 2;
  localparam int RANK_W    = 4;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int CMP_W     = (CNT_W > RANK_W) ? CNT_W : RANK_W;
  localparam int ENTRY_W   = KEY_BITS + SEV_BITS + TIME_BITS;
  localparam int ORD_W     = SEV_BITS + TIME_BITS + IDX_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_UPDATE = 2'd0,
    FUNC_CLEAR  = 2'd1,
    FUNC_RANK   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [SEV_BITS-1:0]  sev;
    logic [TIME_BITS-1:0] tm;
  } entry_t;

  typedef struct packed {
    logic                 ok;
    logic [KEY_BITS-1:0]  key;
    logic [SEV_BITS-1:0]  sev;
    logic [TIME_BITS-1:0] tm;
  } rsp_t;

  typedef struct packed {
    logic             set;
    logic             clr;
    logic             clr_all;
    logic [IDX_W-1:0] idx;
  } vld_op_t;

endpackage

@@ hw/rtl/srat_if.sv @@
// Request and response channel interfaces of the alert table.
interface srat_req_if import srat_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [KEY_BITS-1:0]  key;
  logic [SEV_BITS-1:0]  severity;
  logic [TIME_BITS-1:0] time_ms;
  logic [RANK_W-1:0]    rank_index;

  modport source (output valid, func, key, severity, time_ms, rank_index, input ready);
  modport sink   (input valid, func, key, severity, time_ms, rank_index, output ready);
endinterface

interface srat_rsp_if import srat_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [KEY_BITS-1:0]  out_key;
  logic [SEV_BITS-1:0]  out_severity;
  logic [TIME_BITS-1:0] out_time;
  logic [CNT_W-1:0]     active_count;

  modport source (output valid, ok, out_key, out_severity, out_time, active_count, input ready);
  modport sink   (input valid, ok, out_key, out_severity, out_time, active_count, output ready);
endinterface

@@ hw/rtl/srat_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module srat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/srat_engine.sv @@
// Sequencer and scan datapath: match, eviction and ranked selection over the entry RAM.
module srat_engine import srat_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [FUNC_W-1:0]    func,
  input  logic [KEY_BITS-1:0]  key,
  input  logic [SEV_BITS-1:0]  severity,
  input  logic [TIME_BITS-1:0] time_ms,
  input  logic [RANK_W-1:0]    rank_index,
  input  logic [ENTRIES-1:0]   vld,
  input  logic [CNT_W-1:0]     count,
  input  logic                 slot_free,
  output logic                 idle,
  output logic                 done,
  output rsp_t                 rsp,
  output vld_op_t              vop,
  output logic                 ram_wr_en,
  output logic [IDX_W-1:0]     ram_wr_addr,
  output entry_t               ram_wr_data,
  output logic                 ram_rd_en,
  output logic [IDX_W-1:0]     ram_rd_addr,
  input  entry_t               ram_rd_data
);

  state_t state, state_next;

  logic                 issuing;
  logic [IDX_W-1:0]     issue_idx;
  logic                 data_vld;
  logic [IDX_W-1:0]     data_idx;

  logic [FUNC_W-1:0]    op_func;
  logic [KEY_BITS-1:0]  op_key;
  logic [SEV_BITS-1:0]  op_sev;
  logic [TIME_BITS-1:0] op_tm;
  logic [RANK_W-1:0]    op_rank;

  logic                 match_found;
  logic [IDX_W-1:0]     match_idx;
  logic [SEV_BITS-1:0]  min_sev;
  logic [IDX_W-1:0]     min_idx;

  logic [RANK_W-1:0]    pass;
  logic                 has_bound;
  logic [ORD_W-1:0]     bound;
  logic                 best_found;
  logic [ORD_W-1:0]     best_ord;
  entry_t               best_entry;

  logic                 rank_ok;
  logic                 scan_op;
  logic                 rescan;
  logic                 last_data;
  logic [ORD_W-1:0]     cur_ord;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic                 store;
  logic [IDX_W-1:0]     slot;

  assign rank_ok   = CMP_W'(rank_index) < CMP_W'(count);
  assign scan_op   = (func == FUNC_UPDATE) || ((func == FUNC_RANK) && rank_ok);
  assign last_data = data_vld && (data_idx == LAST_IDX);
  assign rescan    = (op_func == FUNC_RANK) && best_found && (pass != op_rank);
  // Sort order: severity, then time, then lower slot first.
  assign cur_ord   = {ram_rd_data.sev, ram_rd_data.tm, ~data_idx};

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!vld[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    store = 1'b0;
    slot  = match_idx;
    if (op_sev != '0) begin
      priority if (match_found) begin
        store = 1'b1;
        slot  = match_idx;
      end else if (free_found) begin
        store = 1'b1;
        slot  = free_idx;
      end else if (op_sev >= min_sev) begin
        store = 1'b1;
        slot  = min_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    idle       = 1'b0;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          state_next = scan_op ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (last_data) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = rescan ? ST_SCAN : ST_DONE;
      end
      ST_DONE: begin
        done = slot_free;
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign ram_rd_en   = issuing;
  assign ram_rd_addr = issue_idx;
  assign ram_wr_en   = (state == ST_DECIDE) && (op_func == FUNC_UPDATE) && store;
  assign ram_wr_addr = slot;
  assign ram_wr_data = '{key: op_key, sev: op_sev, tm: op_tm};

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      issue_idx <= '0;
      data_vld  <= 1'b0;
    end else begin
      data_vld <= issuing;
      if ((state == ST_IDLE && start && scan_op) || (state == ST_DECIDE && rescan)) begin
        issuing   <= 1'b1;
        issue_idx <= '0;
      end else if (issuing) begin
        issue_idx <= issue_idx + 1'b1;
        if (issue_idx == LAST_IDX) begin
          issuing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    data_idx <= issue_idx;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          op_func     <= func;
          op_key      <= key;
          op_sev      <= severity;
          op_tm       <= time_ms;
          op_rank     <= rank_index;
          match_found <= 1'b0;
          best_found  <= 1'b0;
          has_bound   <= 1'b0;
          pass        <= '0;
          rsp         <= '{ok: (func == FUNC_CLEAR), default: '0};
          vop         <= '{clr_all: (func == FUNC_CLEAR), default: '0};
        end
      end
      ST_SCAN: begin
        if (data_vld) begin
          if (op_func == FUNC_UPDATE) begin
            if (vld[data_idx] && ram_rd_data.key == op_key && !match_found) begin
              match_found <= 1'b1;
              match_idx   <= data_idx;
            end
            if (data_idx == '0 || ram_rd_data.sev < min_sev) begin
              min_sev <= ram_rd_data.sev;
              min_idx <= data_idx;
            end
          end else begin
            if (vld[data_idx] && (!has_bound || cur_ord < bound) &&
                (!best_found || cur_ord > best_ord)) begin
              best_found <= 1'b1;
              best_ord   <= cur_ord;
              best_entry <= ram_rd_data;
            end
          end
        end
      end
      ST_DECIDE: begin
        if (op_func == FUNC_UPDATE) begin
          if (op_sev == '0) begin
            if (match_found) begin
              rsp.ok  <= 1'b1;
              vop.clr <= 1'b1;
              vop.idx <= match_idx;
            end
          end else if (store) begin
            rsp.ok  <= 1'b1;
            vop.set <= 1'b1;
            vop.idx <= slot;
          end
        end else if (best_found) begin
          if (pass == op_rank) begin
            rsp <= '{ok: 1'b1, key: best_entry.key, sev: best_entry.sev, tm: best_entry.tm};
          end else begin
            pass       <= pass + 1'b1;
            bound      <= best_ord;
            has_bound  <= 1'b1;
            best_found <= 1'b0;
          end
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/severity_ranked_alert_table_core.sv @@
// Top level of the severity ranked alert table: valid bits, count, result register.
// Update or remove: a walk of the 16-entry RAM, then a decide step, before the result.
// Ranked read: one full RAM walk per rank step.
// Clear all, unused code, rank beyond count: no RAM walk. One transaction in flight at a time.
// Result register lets the next request be taken while a result waits.
// Reset clears valid bits, count and handshake state; entry RAM is not cleared.
module severity_ranked_alert_table_core import srat_pkg::*; (
  input logic      clk,
  input logic      rst,
  srat_req_if.sink   req,
  srat_rsp_if.source rsp
);

  logic [ENTRIES-1:0] vld;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               slot_free;
  logic               idle;
  logic               done;
  rsp_t               eng_rsp;
  vld_op_t            vop;
  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  entry_t             ram_wr_data;
  logic               ram_rd_en;
  logic [IDX_W-1:0]   ram_rd_addr;
  entry_t             ram_rd_data;
  logic               out_valid;

  assign slot_free = !out_valid || rsp.ready;
  assign req.ready = idle;

  srat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  srat_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .start       (req.valid && req.ready),
    .func        (req.func),
    .key         (req.key),
    .severity    (req.severity),
    .time_ms     (req.time_ms),
    .rank_index  (req.rank_index),
    .vld         (vld),
    .count       (count),
    .slot_free   (slot_free),
    .idle        (idle),
    .done        (done),
    .rsp         (eng_rsp),
    .vop         (vop),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  always_comb begin
    count_next = count;
    priority if (vop.clr_all) begin
      count_next = '0;
    end else if (vop.set && !vld[vop.idx]) begin
      count_next = count + CNT_W'(1);
    end else if (vop.clr && vld[vop.idx]) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (done) begin
        count     <= count_next;
        out_valid <= 1'b1;
        priority if (vop.clr_all) begin
          vld <= '0;
        end else if (vop.set) begin
          vld[vop.idx] <= 1'b1;
        end else if (vop.clr) begin
          vld[vop.idx] <= 1'b0;
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp.ok           <= eng_rsp.ok;
      rsp.out_key      <= eng_rsp.key;
      rsp.out_severity <= eng_rsp.sev;
      rsp.out_time     <= eng_rsp.tm;
      rsp.active_count <= count_next;
    end
  end

  assign rsp.valid = out_valid;

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'($countones(vld)))
    else $error("active count differs from valid bits");

  a_done_needs_slot: assert property (@(posedge clk) disable iff (rst)
    done |-> (!out_valid || rsp.ready))
    else $error("result overwrites an untaken transaction");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second request taken while busy");

  a_write_not_idle: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> !idle)
    else $error("RAM written while idle");

endmodule
